FILE: rtl/core/mlp241_pkg.sv
// Shared types, constants and sigmoid lookup for the 2-4-1 perceptron core.
// No dependencies; used by every module in rtl/core.
`default_nettype none

package mlp241_pkg;

  typedef logic signed [15:0] q412_t;

  localparam int PROD_W     = 33;   // unsigned Q0.16 activation x signed Q4.12 weight
  localparam int ACC_W      = 35;   // sum of up to four output products
  localparam int MAX_NODES  = 4;
  localparam int TBL_DEPTH  = 256;
  localparam int HALF_DEPTH = TBL_DEPTH / 2;

  localparam logic [63:0] Q62_ONE = 64'd1 << 62;

  typedef logic [TBL_DEPTH-1:0][15:0] sig_table_t;

  // (a * b) >> 62 for Q62 fractions, full-width product
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // restoring long division, only used while the table is built
  function automatic logic [63:0] div_u64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], a[i]};
      if (rem >= {1'b0, b}) begin
        rem  = rem - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Entry k = round(65535 / (1 + e^-(k/16 - 8 + 1/32))), integer math only.
  // Evaluated once at elaboration.
  function automatic sig_table_t build_sig_table();
    sig_table_t  tbl;
    logic [63:0] term;
    logic [63:0] e1;
    logic [63:0] step;
    logic [63:0] cur;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] v;
    term = Q62_ONE;
    e1   = Q62_ONE;
    // e^(-1/32), Taylor series
    for (int n = 1; n < 24; n++) begin
      term = div_u64(term, 64'(32 * n));
      if ((n & 1) != 0) begin
        e1 = e1 - term;
      end else begin
        e1 = e1 + term;
      end
    end
    step = mul_q62(e1, e1);
    cur  = e1;
    num  = 64'd65535 << 41;
    for (int j = 0; j < HALF_DEPTH; j++) begin
      den = (Q62_ONE + cur) >> 22;
      v   = div_u64(num + den, den << 1);
      if (v > 64'd65535) begin
        v = 64'd65535;
      end
      tbl[HALF_DEPTH + j]     = v[15:0];
      tbl[HALF_DEPTH - 1 - j] = 16'hFFFF - v[15:0];
      cur = mul_q62(cur, step);
    end
    return tbl;
  endfunction

  localparam sig_table_t SIG_TABLE = build_sig_table();

  // saturate to Q4.12 range, index by top byte offset by 128
  function automatic logic [15:0] activate(input logic signed [31:0] v);
    logic signed [15:0] s;
    if (v > 32767) begin
      s = 16'sh7FFF;
    end else if (v < -32768) begin
      s = 16'sh8000;
    end else begin
      s = v[15:0];
    end
    return SIG_TABLE[{~s[15], s[14:8]}];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mlp241_lane.sv
// One hidden-node lane: input products, activation, output-weight product.
// Depends on mlp241_pkg.
`default_nettype none

module mlp241_lane (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire mlp241_pkg::q412_t                    x1,
  input  wire mlp241_pkg::q412_t                    x2,
  input  wire mlp241_pkg::q412_t                    w1,
  input  wire mlp241_pkg::q412_t                    w2,
  input  wire mlp241_pkg::q412_t                    wo,
  output logic signed [mlp241_pkg::PROD_W-1:0]      prod
);

  logic signed [31:0] p1;
  logic signed [31:0] p2;
  logic        [15:0] act;
  logic signed [32:0] hsum;
  logic signed [20:0] hq;

  // floor shift by 12 is a plain bit drop
  assign hsum = {p1[31], p1} + {p2[31], p2};
  assign hq   = hsum[32:12];

  always_ff @(posedge clk) begin
    if (en) begin
      p1   <= 32'(x1) * 32'(w1);
      p2   <= 32'(x2) * 32'(w2);
      act  <= mlp241_pkg::activate(32'(hq));
      prod <= mlp241_pkg::PROD_W'($signed({1'b0, act})) * mlp241_pkg::PROD_W'(wo);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/mlp241_merge.sv
// Merge stage: sums lane products, scales, saturates and looks up the output.
// Depends on mlp241_pkg.
`default_nettype none

module mlp241_merge #(
  parameter int HIDDEN_COUNT = 4
) (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic signed [mlp241_pkg::PROD_W-1:0] prods [HIDDEN_COUNT],
  output logic [15:0]                            pred
);

  localparam int AQ_W = mlp241_pkg::ACC_W - 16;

  logic signed [mlp241_pkg::ACC_W-1:0] acc;
  logic signed [AQ_W-1:0]              aq;

  always_comb begin
    acc = '0;
    for (int n = 0; n < HIDDEN_COUNT; n++) begin
      acc = acc + mlp241_pkg::ACC_W'(prods[n]);
    end
  end

  assign aq = acc[mlp241_pkg::ACC_W-1:16];

  always_ff @(posedge clk) begin
    if (en) begin
      pred <= mlp241_pkg::activate(32'(aq));
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/mlp_two_four_one_inference.sv
// 2-4-1 perceptron inference, sigmoid activations, Q4.12 in / Q0.16 out.
// Input beats pass the product, activation, output-product and merge registers in turn.
// Throughput: one beat per cycle; three lane stages plus the merge stage, all pipelined.
// The whole pipeline holds while the output beat waits on m_tready.
// Reset (rst, synchronous): clears all valids and the three weight registers.
`default_nettype none

module mlp_two_four_one_inference #(
  parameter int HIDDEN_COUNT = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [15:0] first_feature, [31:16] second_feature
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [15:0] prediction
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  typedef enum logic [1:0] {
    REG_W_FIRST  = 2'd0,
    REG_W_SECOND = 2'd1,
    REG_W_OUT    = 2'd2,
    REG_NONE     = 2'd3
  } reg_idx_t;

  // Weight registers, node n in bits 16n+15:16n
  logic [63:0] w_first;
  logic [63:0] w_second;
  logic [63:0] w_out;

  logic     wr;
  reg_idx_t ridx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;
  assign ridx   = reg_idx_t'(paddr[4:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      w_first  <= '0;
      w_second <= '0;
      w_out    <= '0;
    end else if (wr) begin
      unique case (ridx)
        REG_W_FIRST:  w_first  <= pwdata;
        REG_W_SECOND: w_second <= pwdata;
        REG_W_OUT:    w_out    <= pwdata;
        default:      ;  // beyond the map: ignored
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_W_FIRST:  prdata = w_first;
      REG_W_SECOND: prdata = w_second;
      REG_W_OUT:    prdata = w_out;
      default:      prdata = '0;
    endcase
  end

  // Pipeline control: one global enable, output register parts the two sides.
  // vld[0] products, vld[1] activations, vld[2] output products, m_tvalid result.
  logic       en;
  logic [2:0] vld;

  assign en       = ~m_tvalid | m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vld      <= {vld[1:0], s_tvalid};
      m_tvalid <= vld[2];
    end
  end

  // Hidden-node lanes
  mlp241_pkg::q412_t x1;
  mlp241_pkg::q412_t x2;
  logic signed [mlp241_pkg::PROD_W-1:0] prods [HIDDEN_COUNT];

  assign x1 = s_tdata[15:0];
  assign x2 = s_tdata[31:16];

  for (genvar n = 0; n < HIDDEN_COUNT; n++) begin : g_lane
    mlp241_lane u_lane (
      .clk  (clk),
      .en   (en),
      .x1   (x1),
      .x2   (x2),
      .w1   (w_first[16*n +: 16]),
      .w2   (w_second[16*n +: 16]),
      .wo   (w_out[16*n +: 16]),
      .prod (prods[n])
    );
  end

  mlp241_merge #(
    .HIDDEN_COUNT (HIDDEN_COUNT)
  ) u_merge (
    .clk   (clk),
    .en    (en),
    .prods (prods),
    .pred  (m_tdata)
  );

  // Accepted beat always enters the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> vld[0])
    else $error("accepted beat did not enter the pipeline");

  // A beat in the last lane stage reaches the output register when the pipe moves
  a_last_to_out: assert property (@(posedge clk) disable iff (rst)
    (en && vld[2]) |=> m_tvalid)
    else $error("beat lost between lanes and output");

  // A stalled pipe keeps its stage valids
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("stage valid moved during stall");

  // Reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_tvalid && vld == 3'b000))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

FILE: sim/tb_mlp_two_four_one_inference.sv
// Self-checking testbench for mlp_two_four_one_inference (2-4-1 sigmoid perceptron).
// Needs only the RTL: mlp241_pkg, mlp241_lane, mlp241_merge and the top level.
// Beats are predicted from a local fixed-point model and checked in order.
`timescale 1ns / 100ps

module tb_mlp_two_four_one_inference;

  localparam int NODES = mlp241_pkg::MAX_NODES;
  localparam int DEPTH = mlp241_pkg::TBL_DEPTH;
  localparam int LIMIT = 1_000_000;        // cycle guard, far above the slowest legal run
  localparam int DRAIN_CYCLES = 8;         // extra wait after the last predicted beat is back

  // register map: 64-bit registers at 8-byte strides
  localparam logic [4:0] ADDR_W_FIRST  = 5'd0;
  localparam logic [4:0] ADDR_W_SECOND = 5'd8;
  localparam logic [4:0] ADDR_W_OUT    = 5'd16;
  localparam logic [4:0] ADDR_UNMAPPED = 5'd24;  // index three, writes are dropped

  localparam logic [63:0] ONE_Q62 = 64'd1 << 62;

  typedef struct {
    logic [15:0] first;
    logic [15:0] second;
    logic [15:0] prediction;
  } pair_result_t;

  // DUT ports, all inputs known from time zero
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [15:0] first_feature, [31:16] second_feature
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [15:0] prediction
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  // shadow copies of the weight registers
  logic [63:0] weights_in1 = '0;
  logic [63:0] weights_in2 = '0;
  logic [63:0] weights_out = '0;

  logic [15:0]  sigmoid_lut [DEPTH];
  pair_result_t predictions_due [$];
  pair_result_t head;
  int           mismatches = 0;
  int           cycle_count = 0;
  int           sink_wait = 0;
  bit           src_gaps = 1'b0;    // sender inserts idle cycles
  bit           sink_busy = 1'b0;   // receiver stalls m_tready

  mlp_two_four_one_inference #(.HIDDEN_COUNT(NODES)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------

  // (a * b) >> 62 on Q62 fractions, keeping the full product
  function automatic logic [63:0] q62_product(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Sigmoid sampled at bin centers, odd-symmetric between entries 127 and 128.
  // e^(-1/32) from a Taylor series, then powers of e^(-1/16) walk outward.
  function automatic void fill_sigmoid_lut();
    logic [63:0] term;
    logic [63:0] e_step;
    logic [63:0] ratio;
    logic [63:0] pw;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] v;
    term   = ONE_Q62;
    e_step = ONE_Q62;
    for (int n = 1; n < 24; n++) begin
      term = term / 64'(32 * n);
      if (n % 2 == 1) begin
        e_step = e_step - term;
      end else begin
        e_step = e_step + term;
      end
    end
    ratio = q62_product(e_step, e_step);
    pw    = e_step;
    num   = 64'd65535 << 41;
    for (int j = 0; j < DEPTH / 2; j++) begin
      den = (ONE_Q62 + pw) >> 22;
      v   = (num + den) / (64'd2 * den);
      if (v > 64'd65535) begin
        v = 64'd65535;
      end
      sigmoid_lut[DEPTH / 2 + j]     = v[15:0];
      sigmoid_lut[DEPTH / 2 - 1 - j] = 16'hFFFF - v[15:0];
      pw = q62_product(pw, ratio);
    end
  endfunction

  function automatic longint signed weight_of(logic [63:0] bank, int n);
    logic signed [15:0] w;
    w = bank[16 * n +: 16];
    return longint'(w);
  endfunction

  // clamp a Q4.12 value to [-8, 8) and look it up by its top byte
  function automatic logic [15:0] squash(longint signed q);
    longint signed idx;
    if (q > 32767) begin
      q = 32767;
    end
    if (q < -32768) begin
      q = -32768;
    end
    idx = (q + 32768) >>> 8;
    return sigmoid_lut[idx[7:0]];
  endfunction

  function automatic logic [15:0] sigmoid_net_output(logic [15:0] first, logic [15:0] second);
    mlp241_pkg::q412_t f1;
    mlp241_pkg::q412_t f2;
    longint signed     hsum;
    longint signed     act;
    longint signed     acc;
    f1  = first;
    f2  = second;
    acc = 0;
    for (int n = 0; n < NODES; n++) begin
      hsum = longint'(f1) * weight_of(weights_in1, n) + longint'(f2) * weight_of(weights_in2, n);
      act  = longint'(squash(hsum >>> 12));   // floor shift, Q8.24 -> Q4.12
      acc  = acc + act * weight_of(weights_out, n);
    end
    return squash(acc >>> 16);              // Q4.28 -> Q4.12
  endfunction

  // ---------------------------------------------------------------------------
  // Random picks
  // ---------------------------------------------------------------------------

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [15:0] pick_feature();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 16'($urandom);
    if (r < 7) return 16'($urandom_range(0, 24576) - 12288);   // within +/-3.0
    if (r < 9) return 16'($urandom_range(0, 512) - 256);       // near zero
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0001;
      default: return 16'h0000;
    endcase
  endfunction

  function automatic logic [15:0] pick_weight();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 16'($urandom);
    if (r < 8) return 16'($urandom_range(0, 12288) - 6144);    // within +/-1.5
    if (r < 9) return 16'h7FFF;
    return 16'h8000;
  endfunction

  function automatic logic [63:0] pick_bank();
    return {pick_weight(), pick_weight(), pick_weight(), pick_weight()};
  endfunction

  // ---------------------------------------------------------------------------
  // Bus tasks. All enter and leave at a falling edge.
  // ---------------------------------------------------------------------------

  task automatic reg_write(logic [4:0] addr, logic [63:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (addr)
      ADDR_W_FIRST:  weights_in1 = data;
      ADDR_W_SECOND: weights_in2 = data;
      ADDR_W_OUT:    weights_out = data;
      default:       ;                     // unmapped, write is dropped
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_read_check(logic [4:0] addr, logic [63:0] want);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $display("%0t: register read at 0x%0h: expected %h, actual %h", $time, addr, want, prdata);
      mismatches++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_weights(logic [63:0] w1, logic [63:0] w2, logic [63:0] wo);
    reg_write(ADDR_W_FIRST, w1);
    reg_write(ADDR_W_SECOND, w2);
    reg_write(ADDR_W_OUT, wo);
  endtask

  // One input beat. tvalid stays high into the next call unless a gap is drawn,
  // so it never sees two assignments in one step.
  task automatic send_pair(logic [15:0] first, logic [15:0] second);
    int gap;
    pair_result_t item;
    gap = src_gaps ? idle_len() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {second, first};
    do @(posedge clk); while (!s_tready);
    item.first      = first;
    item.second     = second;
    item.prediction = sigmoid_net_output(first, second);
    predictions_due.push_back(item);
    @(negedge clk);
  endtask

  // stop the stream and wait until every predicted beat has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (predictions_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // after reset all weights read zero; every node then sits at sigmoid(0)
  task automatic test_reset_values();
    reg_read_check(ADDR_W_FIRST, '0);
    reg_read_check(ADDR_W_SECOND, '0);
    reg_read_check(ADDR_W_OUT, '0);
    send_pair(16'h7FFF, 16'h8000);
    send_pair(pick_feature(), pick_feature());
    drain();
  endtask

  // write/readback of each register, and a write to index three that must not land
  task automatic test_register_port();
    load_weights(pick_bank(), pick_bank(), pick_bank());
    reg_read_check(ADDR_W_FIRST, weights_in1);
    reg_read_check(ADDR_W_SECOND, weights_in2);
    reg_read_check(ADDR_W_OUT, weights_out);
    reg_write(ADDR_UNMAPPED, {$urandom, $urandom});
    reg_read_check(ADDR_W_FIRST, weights_in1);
    reg_read_check(ADDR_W_SECOND, weights_in2);
    reg_read_check(ADDR_W_OUT, weights_out);
    repeat (3) send_pair(pick_feature(), pick_feature());
    drain();
  endtask

  // hand-picked corners: saturation both ways, floor on small negatives,
  // extreme weights, mixed-sign lanes
  task automatic test_directed();
    load_weights({4{16'h1000}}, {4{16'h1000}}, {4{16'h1000}});   // all weights 1.0
    send_pair(16'h0000, 16'h0000);
    send_pair(16'h7FFF, 16'h7FFF);     // hidden sum above +8, clamps high
    send_pair(16'h8000, 16'h8000);     // hidden sum below -8, clamps low
    send_pair(16'h7FFF, 16'h8000);
    send_pair(16'hFFFF, 16'h0000);     // -2^-12 must floor, not truncate toward zero
    send_pair(16'h0001, 16'hFFFF);
    send_pair(16'h0100, 16'h0000);     // exactly one table bin above zero
    send_pair(16'hFF00, 16'h00FF);
    drain();
    load_weights({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});   // output sum clamps too
    send_pair(16'h7FFF, 16'h7FFF);
    send_pair(16'h8000, 16'h8000);
    send_pair(16'h8000, 16'h7FFF);
    send_pair(16'h0000, 16'h0000);
    drain();
    load_weights({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
    send_pair(16'h7FFF, 16'h7FFF);
    send_pair(16'h8000, 16'h8000);
    send_pair(16'h0000, 16'h0000);
    send_pair(16'hFFFF, 16'h0001);
    drain();
    // each lane different, so a swapped lane or sign slip shows up
    load_weights({16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF},
                 {16'h2000, 16'hE000, 16'h0000, 16'h1000},
                 {16'h1800, 16'hF000, 16'h7FFF, 16'h8000});
    send_pair(16'h1000, 16'h1000);
    send_pair(16'hF000, 16'h1000);
    send_pair(16'h7FFF, 16'h0000);
    send_pair(16'h0000, 16'h8000);
    send_pair(16'h0800, 16'hF800);
    drain();
  endtask

  // Random weights per phase, random features, with and without idle cycles on
  // either side. Phases five and six hold the weight extremes.
  task automatic test_random_traffic(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      case (p)
        5:       load_weights({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});
        6:       load_weights({4{16'h8000}}, pick_bank(), {4{16'h8000}});
        default: load_weights(pick_bank(), pick_bank(), pick_bank());
      endcase
      src_gaps  = (p % 3 != 0);
      sink_busy = (p % 4 != 1);
      repeat (per_phase) send_pair(pick_feature(), pick_feature());
      drain();
    end
    src_gaps  = 1'b0;
    sink_busy = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // receiver: ready changes at the falling edge, stalls drawn from idle_len
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (sink_wait > 0) begin
      m_tready <= 1'b0;
      sink_wait = sink_wait - 1;
    end else begin
      m_tready <= 1'b1;
      sink_wait = sink_busy ? idle_len() : 0;
    end
  end

  // every accepted result beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (predictions_due.size() == 0) begin
        $display("%0t: result beat with nothing predicted: expected none, actual %h",
                 $time, m_tdata);
        mismatches++;
      end else begin
        head = predictions_due.pop_front();
        if (m_tdata !== head.prediction) begin
          $display("%0t: prediction for (%h, %h): expected %h, actual %h",
                   $time, head.first, head.second, head.prediction, m_tdata);
          mismatches++;
        end
      end
    end
  end

  // run guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("mlp_two_four_one_inference regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    fill_sigmoid_lut();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_values();
    test_register_port();
    test_directed();
    test_random_traffic(8, 240);

    drain();
    if (mismatches == 0 && predictions_due.size() == 0) begin
      $display("mlp_two_four_one_inference regression: pass");
    end else begin
      $display("mlp_two_four_one_inference regression: fail");
    end
    $finish;
  end

endmodule
